// ===== rtl/core/sapm_pkg.sv =====
// ----------------------------------------------------------------------------
// sapm_pkg: shared types and constants of the slot allocator
// Holds the command codes, register addresses and the structs that travel
// along the cell chain and from the controller to the cells.
// ----------------------------------------------------------------------------
package sapm_pkg;

   localparam int DEFAULT_SLOTS = 64;
   localparam int MAX_SLOTS     = 1024;
   localparam int IDX_W         = $clog2(MAX_SLOTS);
   localparam int ADDRESSABLE   = 64;
   localparam int POS_W         = 32;
   localparam int ACT_W         = 7;
   localparam int SLOT_W        = 6;
   localparam int DATA_W        = 32;
   localparam int ADDR_W        = 3;

   localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(64);

   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_FREE     = 1'b1;

   localparam logic REG_ACTIVE_SLOTS = 1'b0;

   typedef struct packed {
      logic             valid;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
      logic             map_found;
      logic [IDX_W-1:0] map_idx;
   } token_type;

   typedef struct packed {
      logic             alloc_en;
      logic [IDX_W-1:0] alloc_idx;
      logic             unmap_en;
      logic [IDX_W-1:0] unmap_idx;
      logic             release_en;
      logic [IDX_W-1:0] release_idx;
   } commit_type;

endpackage

// ===== rtl/core/sapm_cell.sv =====
// ----------------------------------------------------------------------------
// sapm_cell: one storage slot of the allocator chain
// Holds the occupied flag, mapped flag and recorded position of one slot,
// marks itself on the passing search token and applies broadcast updates.
// ----------------------------------------------------------------------------
module sapm_cell #(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [sapm_pkg::POS_W-1:0] position,
   input  logic [sapm_pkg::ACT_W-1:0] active_slots,
   input  sapm_pkg::token_type       token_in,
   output sapm_pkg::token_type       token_out,
   input  sapm_pkg::commit_type      commit
);
   import sapm_pkg::*;

   localparam bit IN_RANGE = INDEX < ADDRESSABLE;
   localparam logic [ACT_W-1:0] IDX_A = IN_RANGE ? ACT_W'(INDEX) : '0;
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic             occupied_ff, occupied_in;
   logic             mapped_ff, mapped_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   token_type        token_ff, token_nxt_in;
   logic             free_ok;
   logic             map_hit;

   assign free_ok = IN_RANGE && !occupied_ff && (active_slots > IDX_A);
   assign map_hit = mapped_ff && (pos_ff == position);

   always_comb begin
      token_nxt_in = token_in;
      if (token_in.valid && !token_in.free_found && free_ok) begin
         token_nxt_in.free_found = 1'b1;
         token_nxt_in.free_idx   = MY_IDX;
      end
      if (token_in.valid && !token_in.map_found && map_hit) begin
         token_nxt_in.map_found = 1'b1;
         token_nxt_in.map_idx   = MY_IDX;
      end
   end

   always_comb begin
      occupied_in = occupied_ff;
      mapped_in   = mapped_ff;
      pos_in      = pos_ff;
      if (commit.alloc_en && commit.alloc_idx == MY_IDX) begin
         occupied_in = 1'b1;
         mapped_in   = 1'b1;
         pos_in      = position;
      end
      if (commit.unmap_en && commit.unmap_idx == MY_IDX) begin
         mapped_in = 1'b0;
      end
      if (commit.release_en && commit.release_idx == MY_IDX) begin
         occupied_in = 1'b0;
         mapped_in   = 1'b0;
         pos_in      = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= 1'b0;
         mapped_ff   <= 1'b0;
         pos_ff      <= '1;
         token_ff    <= '0;
      end else begin
         occupied_ff <= occupied_in;
         mapped_ff   <= mapped_in;
         pos_ff      <= pos_in;
         token_ff    <= token_nxt_in;
      end
   end

   assign token_out = token_ff;

endmodule

// ===== rtl/core/slot_allocator_with_position_map_unit.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_with_position_map_unit: first-free slot allocator
// A request carries a command in req_tuser (allocate or free) and a token
// position in req_tdata. Allocate takes the lowest free slot among the
// active ones and maps the position to it, dropping any earlier mapping of
// that position. Free releases the slot mapped to the position.
// Each response carries ok in rsp_tuser and the slot index in rsp_tdata.
// A request is held in a register while a search token walks the chain of
// slot cells, one cell per cycle. The result is captured when the token
// leaves the last cell and then loaded into the output register, and a new
// request is taken only after the previous response is loaded.
// The active slot count is to be written over the csr_ port only while idle;
// the user must keep to this, as the block itself does not enforce it.
// Reset frees every slot, clears every mapping and sets 64 active slots.
// When the receiver stalls, the response waits in its output register; a
// following request is accepted and searched, and its update waits until
// the output register is free.
// ----------------------------------------------------------------------------
module slot_allocator_with_position_map_unit #(
   parameter int SLOTS = sapm_pkg::DEFAULT_SLOTS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sapm_pkg::POS_W-1:0]   req_tdata,   // position
   input  logic                         req_tuser,   // command
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // slot_index, zero pad
   output logic                         rsp_tuser,   // ok
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sapm_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [sapm_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [sapm_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import sapm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LAUNCH = 4'b0010,
      S_SCAN   = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic             cmd_ff, cmd_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [ACT_W-1:0] active_ff, active_in;
   token_type        result_ff, result_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   token_type        chain [SLOTS+1];
   token_type        launch_token;
   commit_type       commit;
   logic             req_fire;
   logic             load;
   logic             res_ok;
   logic [IDX_W-1:0] res_idx;

   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign load       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      launch_token       = '0;
      launch_token.valid = state_ff == S_LAUNCH;
   end

   assign chain[0] = launch_token;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      sapm_cell #(
         .INDEX(i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .position    (pos_ff),
         .active_slots(active_ff),
         .token_in    (chain[i]),
         .token_out   (chain[i+1]),
         .commit      (commit)
      );
   end

   always_comb begin
      if (cmd_ff == CMD_FREE) begin
         res_ok  = result_ff.map_found;
         res_idx = result_ff.map_idx;
      end else begin
         res_ok  = result_ff.free_found;
         res_idx = result_ff.free_idx;
      end
   end

   always_comb begin
      commit             = '0;
      commit.alloc_idx   = result_ff.free_idx;
      commit.unmap_idx   = result_ff.map_idx;
      commit.release_idx = result_ff.map_idx;
      if (load && cmd_ff == CMD_ALLOCATE && result_ff.free_found) begin
         commit.alloc_en = 1'b1;
         commit.unmap_en = result_ff.map_found;
      end
      if (load && cmd_ff == CMD_FREE && result_ff.map_found) begin
         commit.release_en = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_tuser;
               pos_in   = req_tdata;
               state_in = S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (chain[SLOTS].valid) begin
               result_in = chain[SLOTS];
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok;
               rsp_slot_in  = res_ok ? res_idx[SLOT_W-1:0] : '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      active_in = active_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == REG_ACTIVE_SLOTS) begin
         active_in = csr_pwdata[ACT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= ACTIVE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pos_ff      <= pos_in;
      result_ff   <= result_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {2'b00, rsp_slot_ff};
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ACTIVE_SLOTS)
                       ? {{(DATA_W-ACT_W){1'b0}}, active_ff} : '0;

endmodule

// ===== tb/sv/tb_slot_allocator_with_position_map_unit.sv =====
// ----------------------------------------------------------------------------
// tb_slot_allocator_with_position_map_unit: self-checking slot allocator test
// Streams allocate and free requests into the block while the active slot
// count is rewritten between phases over the csr_ port. Each accepted request
// is run through a local slot table, which predicts the ok flag and slot
// index of its response. Responses are checked in order against those
// predictions under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_slot_allocator_with_position_map_unit;

   import sapm_pkg::*;

   localparam int TRACKED_SLOTS = DEFAULT_SLOTS;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_REQUESTS = 210;
   localparam int STEADY_PHASE = 3;
   localparam int SETTLE_CYCLES = TRACKED_SLOTS + 16;
   localparam logic [ADDR_W-1:0] ACTIVE_SLOTS_ADDR = ADDR_W'(4 * REG_ACTIVE_SLOTS);
   // Slot counts of the random phases, phase 0 in the lowest bits.
   localparam logic [RANDOM_PHASES*ACT_W-1:0] PHASE_SETTINGS =
      {7'd64, 7'd17, 7'd100, 7'd1, 7'd48, 7'd2, 7'd127, 7'd64};

   typedef struct packed {
      logic             command;
      logic [POS_W-1:0] position;
   } slot_request_type;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot_index;
   } slot_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [POS_W-1:0]   req_tdata = '0;   // position
   logic               req_tuser = 1'b0; // command
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;        // slot_index, zero pad
   logic               rsp_tuser;        // ok
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]  csr_paddr = '0;
   logic [DATA_W-1:0]  csr_pwdata = '0;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   slot_request_type pending_slot_requests[$];
   slot_result_type  expected_slot_results[$];
   logic [POS_W-1:0] live_positions[$];

   bit               slot_busy[TRACKED_SLOTS];
   bit               slot_mapped[TRACKED_SLOTS];
   logic [POS_W-1:0] slot_owner[TRACKED_SLOTS];
   logic [ACT_W-1:0] active_setting = ACTIVE_RESET;

   logic steady_stretch = 1'b0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   mismatch_count = 0;
   int   accepted_requests = 0;
   int   checked_responses = 0;
   int   config_writes = 0;
   int   alloc_hits = 0;
   int   alloc_full = 0;
   int   free_hits = 0;
   int   free_misses = 0;

   slot_allocator_with_position_map_unit #(
      .SLOTS(TRACKED_SLOTS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < TRACKED_SLOTS; i++) begin
         slot_busy[i] = 1'b0;
         slot_mapped[i] = 1'b0;
         slot_owner[i] = '1;
      end
   end

   function automatic slot_result_type apply_slot_request(logic command,
                                                          logic [POS_W-1:0] position);
      slot_result_type outcome;
      int limit;
      int free_slot;
      int owner_slot;
      outcome = '0;
      limit = active_setting;
      if (limit > TRACKED_SLOTS) limit = TRACKED_SLOTS;
      if (limit > ADDRESSABLE) limit = ADDRESSABLE;
      owner_slot = -1;
      for (int i = 0; i < TRACKED_SLOTS; i++) begin
         if (owner_slot < 0 && slot_mapped[i] && slot_owner[i] == position) owner_slot = i;
      end
      if (command == CMD_ALLOCATE) begin
         free_slot = -1;
         for (int i = 0; i < limit; i++) begin
            if (free_slot < 0 && !slot_busy[i]) free_slot = i;
         end
         if (free_slot >= 0) begin
            if (owner_slot >= 0) slot_mapped[owner_slot] = 1'b0;
            slot_busy[free_slot] = 1'b1;
            slot_owner[free_slot] = position;
            slot_mapped[free_slot] = 1'b1;
            outcome.ok = 1'b1;
            outcome.slot_index = SLOT_W'(free_slot);
            alloc_hits++;
         end else begin
            alloc_full++;
         end
      end else if (owner_slot >= 0) begin
         slot_busy[owner_slot] = 1'b0;
         slot_owner[owner_slot] = '1;
         slot_mapped[owner_slot] = 1'b0;
         outcome.ok = 1'b1;
         outcome.slot_index = SLOT_W'(owner_slot);
         free_hits++;
      end else begin
         free_misses++;
      end
      return outcome;
   endfunction

   // Request driver: predicts each request when it is accepted.
   always @(posedge clock) begin
      slot_request_type next_request;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_slot_results = {expected_slot_results,
                                     apply_slot_request(req_tuser, req_tdata)};
            accepted_requests++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_slot_requests.size() != 0 &&
                         (steady_stretch || $urandom_range(99) >= 33)) begin
               next_request = pending_slot_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_request.command;
               req_tdata <= next_request.position;
               if (!steady_stretch && $urandom_range(49) == 0) send_gap = $urandom_range(1, 80);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with short and long receiver stalls.
   always @(posedge clock) begin
      slot_result_type oldest;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked_responses++;
            if (expected_slot_results.size() == 0) begin
               $error("response with no request outstanding: ok %0b slot_index %0d",
                      rsp_tuser, rsp_tdata);
               mismatch_count++;
            end else begin
               oldest = expected_slot_results.pop_front();
               if (rsp_tuser !== oldest.ok) begin
                  $error("ok: expected %0b, actual %0b", oldest.ok, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata !== {2'b00, oldest.slot_index}) begin
                  $error("slot_index: expected %0d, actual %0d", oldest.slot_index, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!steady_stretch && $urandom_range(99) == 0) begin
            stall_left = $urandom_range(20, 150);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady_stretch || ($urandom_range(99) >= 33);
         end
      end
   end

   task automatic queue_request(logic command, logic [POS_W-1:0] position);
      slot_request_type entry;
      entry.command = command;
      entry.position = position;
      pending_slot_requests = {pending_slot_requests, entry};
   endtask

   task automatic wait_until_idle();
      while (pending_slot_requests.size() != 0 || req_tvalid ||
             expected_slot_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_active_slots(logic [ACT_W-1:0] value);
      wait_until_idle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ACTIVE_SLOTS_ADDR;
      csr_pwdata <= DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      active_setting = value;
      config_writes++;
   endtask

   initial begin
      int roll;
      int pick;
      int alloc_share;
      logic [POS_W-1:0] position;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Fresh table: unknown positions, extremes, a remap that orphans a slot.
      queue_request(CMD_FREE, 32'hFFFF_FFFF);
      queue_request(CMD_FREE, 32'h0000_0000);
      queue_request(CMD_ALLOCATE, 32'h8000_0000);
      queue_request(CMD_ALLOCATE, 32'h7FFF_FFFF);
      queue_request(CMD_ALLOCATE, 32'h0000_0000);
      queue_request(CMD_ALLOCATE, 32'hFFFF_FFFF);
      queue_request(CMD_ALLOCATE, 32'h7FFF_FFFF);
      queue_request(CMD_FREE, 32'h7FFF_FFFF);
      queue_request(CMD_FREE, 32'h7FFF_FFFF);
      queue_request(CMD_FREE, 32'h8000_0000);
      queue_request(CMD_ALLOCATE, 32'h0000_0005);

      // One active slot: full table keeps the old mapping, and a slot beyond
      // the active count can still be freed.
      write_active_slots(7'd1);
      queue_request(CMD_ALLOCATE, 32'h0000_000A);
      queue_request(CMD_FREE, 32'h0000_0005);
      queue_request(CMD_ALLOCATE, 32'h0000_000A);
      queue_request(CMD_ALLOCATE, 32'h0000_0000);
      queue_request(CMD_FREE, 32'h0000_0000);

      // No active slots: every allocate fails while frees still work.
      write_active_slots(7'd0);
      queue_request(CMD_ALLOCATE, 32'h5555_5555);
      queue_request(CMD_FREE, 32'h0000_000A);
      queue_request(CMD_ALLOCATE, 32'hAAAA_AAAA);

      // Count above the slot total is clipped to the table size.
      write_active_slots(7'd127);
      queue_request(CMD_ALLOCATE, 32'hAAAA_AAAA);
      queue_request(CMD_ALLOCATE, 32'h5555_5555);
      queue_request(CMD_FREE, 32'hFFFF_FFFF);

      // Random phases: mostly allocates of fresh positions and frees of
      // positions handed out earlier, with some remaps and unknown frees.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_active_slots(PHASE_SETTINGS[phase*ACT_W +: ACT_W]);
         steady_stretch <= (phase == STEADY_PHASE);
         alloc_share = (phase % 2 == 0) ? 60 : 42;
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            roll = $urandom_range(99);
            if (roll < alloc_share || live_positions.size() == 0) begin
               position = $urandom();
               queue_request(CMD_ALLOCATE, position);
               live_positions = {live_positions, position};
            end else if (roll < 88) begin
               pick = $urandom_range(live_positions.size() - 1);
               queue_request(CMD_FREE, live_positions[pick]);
               live_positions.delete(pick);
            end else if (roll < 94) begin
               pick = $urandom_range(live_positions.size() - 1);
               queue_request(CMD_ALLOCATE, live_positions[pick]);
            end else begin
               queue_request(CMD_FREE, $urandom());
            end
         end
      end

      wait_until_idle();
      steady_stretch <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d requests and %0d responses under %0d slot count writes.",
               accepted_requests, checked_responses, config_writes);
      $display("Allocates: %0d placed, %0d full. Frees: %0d released, %0d not found.",
               alloc_hits, alloc_full, free_hits, free_misses);
      if (mismatch_count == 0 && expected_slot_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
